@@ rtl/core/rc_throttle_softstart_ramp_unit_defines.svh @@
// Assertion macros shared by the RTL of the throttle soft-start ramp.
`ifndef RC_THROTTLE_SOFTSTART_RAMP_UNIT_DEFINES_SVH
`define RC_THROTTLE_SOFTSTART_RAMP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define RCTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc throttle ramp: implication check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define RCTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc throttle ramp: next-cycle check failed");

`endif

@@ rtl/core/rcts_pkg.sv @@
package rcts_pkg;

  localparam int PCT_W   = 7;
  localparam int MS_W    = 16;
  localparam int TIME_W  = 32;
  localparam int WIDTH_W = 12;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_MIN_RUN  = 3'd0;
  localparam logic [2:0] REG_KICK_PCT = 3'd1;
  localparam logic [2:0] REG_KICK_MS  = 3'd2;
  localparam logic [2:0] REG_CRAWL_MS = 3'd3;
  localparam logic [2:0] REG_FAIL_MS  = 3'd4;
  localparam logic [2:0] REG_STEP_MS  = 3'd5;
  localparam logic [2:0] REG_PUNCH    = 3'd6;

  // Register reset values.
  localparam logic [PCT_W-1:0] MIN_RUN_RST  = 7'd18;
  localparam logic [PCT_W-1:0] KICK_PCT_RST = 7'd100;
  localparam logic [MS_W-1:0]  KICK_MS_RST  = 16'd150;
  localparam logic [MS_W-1:0]  CRAWL_MS_RST = 16'd400;
  localparam logic [MS_W-1:0]  FAIL_MS_RST  = 16'd200;
  localparam logic [MS_W-1:0]  STEP_MS_RST  = 16'd10;
  localparam logic [PCT_W-1:0] PUNCH_RST    = 7'd95;

  // Pulse width window and mapping points in microseconds.
  localparam logic [WIDTH_W-1:0] W_MIN     = 12'd800;
  localparam logic [WIDTH_W-1:0] W_MAX     = 12'd2200;
  localparam logic [WIDTH_W-1:0] W_LO      = 12'd1000;
  localparam logic [WIDTH_W-1:0] W_HI      = 12'd2000;
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 12'd1500;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W:0]   RAMP_INC = 8'd2;

  // Width to percent: (w - 1000) / 10, clamped to 0..100. The divide by ten
  // is a multiply by 6554 / 2^16, exact for the operand range below 1000.
  function automatic logic [PCT_W-1:0] width_to_pct(input logic [WIDTH_W-1:0] w);
    logic [9:0]  x;
    logic [22:0] prod;
    begin
      x    = 10'(w - W_LO);
      prod = 23'(x) * 23'd6554;
      if (w <= W_LO) begin
        width_to_pct = '0;
      end else if (w >= W_HI) begin
        width_to_pct = PCT_FULL;
      end else begin
        width_to_pct = prod[22:16];
      end
    end
  endfunction

  // Percent to 8-bit compare value: pct * 255 / 100, or 255 above 100.
  // The divide by 100 is a multiply by 5243 / 2^19, exact up to 25500.
  function automatic logic [7:0] pct_to_pwm(input logic [PCT_W-1:0] pct);
    logic [14:0] y;
    logic [27:0] prod;
    begin
      y    = {pct, 8'b0} - 15'(pct);
      prod = 28'(y) * 28'd5243;
      if (pct > PCT_FULL) begin
        pct_to_pwm = 8'hFF;
      end else begin
        pct_to_pwm = prod[26:19];
      end
    end
  endfunction

endpackage

@@ rtl/core/rc_throttle_softstart_ramp_unit.sv @@
// Channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------------------
// input     | in_valid / in_stall       | pulse_valid, pulse_width_us
// output    | out_valid / out_stall     | duty_pct, pwm_duty, drive_enable, target_pct
// config    | APB psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One input transfer is taken per clock cycle while the input is not stalled; its result
// appears in the output register in the next cycle.
// rst is synchronous and active high: it loads the register defaults, clears
// the tick counter and returns the ramp state to its power-up values.
// A stalled output holds its result; the input is stalled only while a result is
// waiting in the output register and the output side stalls.

`include "rc_throttle_softstart_ramp_unit_defines.svh"

module rc_throttle_softstart_ramp_unit
  import rcts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input channel: one transfer is one millisecond tick.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                pulse_valid,
  input  logic [WIDTH_W-1:0]  pulse_width_us,
  // Output channel: one result per tick.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PCT_W-1:0]    duty_pct,
  output logic [7:0]          pwm_duty,
  output logic                drive_enable,
  output logic [PCT_W-1:0]    target_pct,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // Configuration registers.
  logic [PCT_W-1:0] run_floor_pct;
  logic [PCT_W-1:0] kick_pct;
  logic [MS_W-1:0]  kick_ms;
  logic [MS_W-1:0]  crawl_time_ms;
  logic [MS_W-1:0]  silence_ms;
  logic [MS_W-1:0]  step_ms;
  logic [PCT_W-1:0] punch_pct;

  // Ramp state. All times are absolute tick numbers that wrap at 32 bits.
  logic [TIME_W-1:0]  ms_counter;
  logic [WIDTH_W-1:0] last_width;
  logic [TIME_W-1:0]  last_pulse_time;
  logic [PCT_W-1:0]   current_duty;
  logic [TIME_W-1:0]  kick_end_time;
  logic               running_flag;
  logic [TIME_W-1:0]  zero_since_time;
  logic [TIME_W-1:0]  last_step_time;

  logic [WIDTH_W-1:0] last_width_next;
  logic [TIME_W-1:0]  last_pulse_time_next;
  logic [PCT_W-1:0]   current_duty_next;
  logic [TIME_W-1:0]  kick_end_time_next;
  logic               running_flag_next;
  logic [TIME_W-1:0]  zero_since_time_next;
  logic [TIME_W-1:0]  last_step_time_next;
  logic               enable_next;

  logic               in_xfer;
  logic               cfg_write;
  logic [2:0]         cfg_index;

  logic               width_ok;
  logic [PCT_W-1:0]   tgt;
  logic               kick_over;
  logic               failsafe;
  logic               step_due;
  logic [PCT_W-1:0]   duty_settled;
  logic [PCT_W:0]     duty_up;
  logic [PCT_W:0]     duty_down;
  logic               down_ok;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  // The output register is the only buffer, so a new tick is refused only
  // while its result cannot leave.
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Configuration registers: written in the APB access phase, read back
  // from a plain address mux.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      run_floor_pct <= MIN_RUN_RST;
      kick_pct      <= KICK_PCT_RST;
      kick_ms       <= KICK_MS_RST;
      crawl_time_ms <= CRAWL_MS_RST;
      silence_ms    <= FAIL_MS_RST;
      step_ms       <= STEP_MS_RST;
      punch_pct     <= PUNCH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_RUN:  run_floor_pct <= pwdata[PCT_W-1:0];
        REG_KICK_PCT: kick_pct      <= pwdata[PCT_W-1:0];
        REG_KICK_MS:  kick_ms       <= pwdata[MS_W-1:0];
        REG_CRAWL_MS: crawl_time_ms <= pwdata[MS_W-1:0];
        REG_FAIL_MS:  silence_ms    <= pwdata[MS_W-1:0];
        REG_STEP_MS:  step_ms       <= pwdata[MS_W-1:0];
        REG_PUNCH:    punch_pct     <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_MIN_RUN:  prdata = DATA_W'(run_floor_pct);
      REG_KICK_PCT: prdata = DATA_W'(kick_pct);
      REG_KICK_MS:  prdata = DATA_W'(kick_ms);
      REG_CRAWL_MS: prdata = DATA_W'(crawl_time_ms);
      REG_FAIL_MS:  prdata = DATA_W'(silence_ms);
      REG_STEP_MS:  prdata = DATA_W'(step_ms);
      REG_PUNCH:    prdata = DATA_W'(punch_pct);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Tick logic. A pulse inside the 800 to 2200 us window replaces the stored
  // width and restarts the failsafe timer; anything else leaves both alone.
  // ---------------------------------------------------------------------
  assign width_ok = pulse_valid && (pulse_width_us >= W_MIN) && (pulse_width_us <= W_MAX);
  assign last_width_next      = width_ok ? pulse_width_us : last_width;
  assign last_pulse_time_next = width_ok ? ms_counter : last_pulse_time;
  assign tgt = width_to_pct(last_width_next);

  assign failsafe  = (ms_counter - last_pulse_time_next) > TIME_W'(silence_ms);
  assign kick_over = ms_counter > kick_end_time;
  assign step_due  = ((ms_counter - last_step_time) >= TIME_W'(step_ms)) && kick_over;

  // Once the kick has run out, a duty still at or above the kick level drops
  // straight to the target, but never below the minimum run level.
  always_comb begin
    if (kick_over && running_flag && (current_duty >= kick_pct)) begin
      duty_settled = (tgt < run_floor_pct) ? run_floor_pct : tgt;
    end else begin
      duty_settled = current_duty;
    end
  end

  assign duty_up   = {1'b0, duty_settled} + RAMP_INC;
  assign down_ok   = duty_settled >= PCT_W'(RAMP_INC);
  assign duty_down = {1'b0, duty_settled} - RAMP_INC;

  always_comb begin
    current_duty_next    = current_duty;
    kick_end_time_next   = kick_end_time;
    running_flag_next    = running_flag;
    zero_since_time_next = zero_since_time;
    last_step_time_next  = last_step_time;
    enable_next          = 1'b1;

    if (failsafe) begin
      // Pulse silence: drive off, the rest of the ramp state is kept.
      current_duty_next = '0;
      enable_next       = 1'b0;
    end else if ((current_duty == '0) && (tgt != '0) && kick_over) begin
      // Start from standstill: kick at kick_pct until ms_counter passes kick_end_time.
      current_duty_next  = kick_pct;
      kick_end_time_next = ms_counter + TIME_W'(kick_ms);
      running_flag_next  = 1'b1;
    end else begin
      current_duty_next = duty_settled;
      if (step_due) begin
        last_step_time_next = ms_counter;
        if (tgt >= punch_pct) begin
          current_duty_next = PCT_FULL;
        end else if (duty_settled < tgt) begin
          current_duty_next = (duty_up < {1'b0, tgt}) ? duty_up[PCT_W-1:0] : tgt;
        end else if (duty_settled > tgt) begin
          if (tgt == '0) begin
            // Ramp down to the crawl level, hold it, then cut.
            if (duty_settled > run_floor_pct) begin
              current_duty_next = (down_ok && (duty_down > {1'b0, run_floor_pct}))
                                  ? duty_down[PCT_W-1:0] : run_floor_pct;
              zero_since_time_next = ms_counter;
            end else if ((ms_counter - zero_since_time) > TIME_W'(crawl_time_ms)) begin
              current_duty_next = '0;
              running_flag_next = 1'b0;
            end
          end else begin
            current_duty_next = (duty_down > {1'b0, tgt}) ? duty_down[PCT_W-1:0] : tgt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_counter      <= '0;
      last_width      <= WIDTH_RST;
      last_pulse_time <= '0;
      current_duty    <= '0;
      kick_end_time   <= '0;
      running_flag    <= 1'b0;
      zero_since_time <= '0;
      last_step_time  <= '0;
    end else if (in_xfer) begin
      ms_counter      <= ms_counter + 1'b1;
      last_width      <= last_width_next;
      last_pulse_time <= last_pulse_time_next;
      current_duty    <= current_duty_next;
      kick_end_time   <= kick_end_time_next;
      running_flag    <= running_flag_next;
      zero_since_time <= zero_since_time_next;
      last_step_time  <= last_step_time_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register. The compare value is derived from the registered duty.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_xfer || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      duty_pct     <= current_duty_next;
      drive_enable <= enable_next;
      target_pct   <= tgt;
    end
  end

  assign pwm_duty = pct_to_pwm(duty_pct);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `RCTS_ASSERT_IMP(a_off_means_zero, out_valid && !drive_enable, duty_pct == '0)
  `RCTS_ASSERT_IMP(a_target_range, out_valid, target_pct <= PCT_FULL)
  `RCTS_ASSERT_NXT(a_out_tracks_state, in_xfer, out_valid && (duty_pct == current_duty))
  `RCTS_ASSERT_NXT(a_tick_advances, in_xfer, ms_counter == $past(ms_counter) + 1'b1)

endmodule

@@ verif/rcts_drive_checker.sv @@
module rcts_drive_checker
  import rcts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               pulse_valid,
  input  logic [WIDTH_W-1:0] pulse_width_us,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [PCT_W-1:0]   duty_pct,
  input  logic [7:0]         pwm_duty,
  input  logic               drive_enable,
  input  logic [PCT_W-1:0]   target_pct,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PCT_W-1:0] duty;
    logic [7:0]       pwm;
    logic             en;
    logic [PCT_W-1:0] tgt;
  } drive_result_t;

  drive_result_t expected_drive [$];
  int fail_tally = 0;
  int queued = 0;

  assign mismatches = fail_tally;
  assign pending    = queued;

  // Register copy.
  int unsigned cfg_min_run, cfg_kick_pct, cfg_kick_ms, cfg_crawl_ms;
  int unsigned cfg_fail_ms, cfg_step_ms, cfg_punch;

  // Ramp state, times in ticks.
  int unsigned tick_count, held_width, pulse_seen_at, duty_now;
  int unsigned kick_until, crawl_from, stepped_at;
  bit          motor_running;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    fail_tally++;
  endtask

  function automatic int unsigned pct_of_width(input int unsigned w);
    int unsigned p;
    if (w <= 32'(W_LO)) return 0;
    p = ((w - 32'(W_LO)) * 100) / (32'(W_HI) - 32'(W_LO));
    return (p > 100) ? 100 : p;
  endfunction

  // Works out the drive outputs of one millisecond tick and advances the state.
  task automatic predict_drive(input logic pv, input logic [WIDTH_W-1:0] w);
    int unsigned   now;
    int unsigned   tgt;
    int unsigned   pct;
    int            lowered;
    drive_result_t res;
    now        = tick_count;
    tick_count = now + 1;
    res.en     = 1'b1;
    if (pv && w >= W_MIN && w <= W_MAX) begin
      held_width    = w;
      pulse_seen_at = now;
    end
    tgt = pct_of_width(held_width);

    if (now - pulse_seen_at > cfg_fail_ms) begin
      duty_now = 0;
      res.en   = 1'b0;
    end else if (duty_now == 0 && tgt > 0 && now > kick_until) begin
      duty_now      = cfg_kick_pct;
      kick_until    = now + cfg_kick_ms;
      motor_running = 1'b1;
    end else begin
      // Leaving the kick settles on the target, but never below the run floor.
      if (now > kick_until && motor_running && duty_now >= cfg_kick_pct) begin
        duty_now = (tgt < cfg_min_run) ? cfg_min_run : tgt;
      end
      if (now - stepped_at >= cfg_step_ms && now > kick_until) begin
        stepped_at = now;
        if (tgt >= cfg_punch) begin
          duty_now = 100;
        end else if (duty_now < tgt) begin
          duty_now = (duty_now + 2 < tgt) ? duty_now + 2 : tgt;
        end else if (duty_now > tgt) begin
          if (tgt == 0) begin
            if (duty_now > cfg_min_run) begin
              lowered    = int'(duty_now) - 2;
              duty_now   = (lowered > int'(cfg_min_run)) ? 32'(lowered) : cfg_min_run;
              crawl_from = now;
            end else if (now - crawl_from > cfg_crawl_ms) begin
              duty_now      = 0;
              motor_running = 1'b0;
            end
          end else begin
            lowered  = int'(duty_now) - 2;
            duty_now = (lowered > int'(tgt)) ? 32'(lowered) : tgt;
          end
        end
      end
    end

    pct     = duty_now & 32'h7F;
    res.duty = PCT_W'(pct);
    res.pwm  = (pct > 100) ? 8'hFF : 8'((pct * 255) / 100);
    res.tgt  = PCT_W'(tgt);
    expected_drive.push_back(res);
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      expected_drive.delete();
      cfg_min_run   = MIN_RUN_RST;
      cfg_kick_pct  = KICK_PCT_RST;
      cfg_kick_ms   = KICK_MS_RST;
      cfg_crawl_ms  = CRAWL_MS_RST;
      cfg_fail_ms   = FAIL_MS_RST;
      cfg_step_ms   = STEP_MS_RST;
      cfg_punch     = PUNCH_RST;
      tick_count    = 0;
      held_width    = WIDTH_RST;
      pulse_seen_at = 0;
      duty_now      = 0;
      kick_until    = 0;
      motor_running = 1'b0;
      crawl_from    = 0;
      stepped_at    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_MIN_RUN:  cfg_min_run  = pwdata[PCT_W-1:0];
          REG_KICK_PCT: cfg_kick_pct = pwdata[PCT_W-1:0];
          REG_KICK_MS:  cfg_kick_ms  = pwdata[MS_W-1:0];
          REG_CRAWL_MS: cfg_crawl_ms = pwdata[MS_W-1:0];
          REG_FAIL_MS:  cfg_fail_ms  = pwdata[MS_W-1:0];
          REG_STEP_MS:  cfg_step_ms  = pwdata[MS_W-1:0];
          REG_PUNCH:    cfg_punch    = pwdata[PCT_W-1:0];
          default: ;
        endcase
      end
      // Results are taken before new ticks so a stray result cannot match
      // the prediction made at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          report_mismatch("unexpected result, duty_pct", duty_pct, -1);
        end else begin
          want = expected_drive.pop_front();
          if (duty_pct !== want.duty)
            report_mismatch("duty_pct", duty_pct, want.duty);
          if (pwm_duty !== want.pwm)
            report_mismatch("pwm_duty", pwm_duty, want.pwm);
          if (drive_enable !== want.en)
            report_mismatch("drive_enable", drive_enable, want.en);
          if (target_pct !== want.tgt)
            report_mismatch("target_pct", target_pct, want.tgt);
        end
      end
      if (in_valid && !in_stall) predict_drive(pulse_valid, pulse_width_us);
    end
    queued = expected_drive.size();
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top
  import rcts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The whole run stays far below this; hitting it means a hung handshake.
  localparam int CYCLE_LIMIT = 400000;

  // One full register setting, written as a block while the unit is idle.
  typedef struct {
    int unsigned min_run;
    int unsigned kick_pct;
    int unsigned kick_ms;
    int unsigned crawl_ms;
    int unsigned fail_ms;
    int unsigned step_ms;
    int unsigned punch;
  } ramp_setting_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               pulse_valid = 1'b0;
  logic [WIDTH_W-1:0] pulse_width_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PCT_W-1:0]   duty_pct;
  logic [7:0]         pwm_duty;
  logic               drive_enable;
  logic [PCT_W-1:0]   target_pct;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int mismatches;
  int pending;
  int cycle_count = 0;

  // While a side is quiet it neither idles nor stalls, which gives long
  // back-to-back stretches between the randomly throttled ones.
  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rc_throttle_softstart_ramp_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pulse_valid    (pulse_valid),
    .pulse_width_us (pulse_width_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .duty_pct       (duty_pct),
    .pwm_duty       (pwm_duty),
    .drive_enable   (drive_enable),
    .target_pct     (target_pct),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // The checker watches every channel on its own; the top only drives.
  rcts_drive_checker drive_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pulse_valid    (pulse_valid),
    .pulse_width_us (pulse_width_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .duty_pct       (duty_pct),
    .pwm_duty       (pwm_duty),
    .drive_enable   (drive_enable),
    .target_pct     (target_pct),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: before each transfer the stall is held for a random number
  // of cycles, whether or not a result is already waiting, so that stalls
  // land on every phase of the unit's work.
  initial begin : result_sink
    int unsigned hold;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
      hold = sink_quiet ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Sends one tick. It is entered and left at a falling edge. The valid is
  // left high after the transfer so that a following tick with no gap keeps
  // it high; it is lowered only when a gap is drawn or the sender pauses.
  task automatic send_tick(input logic pv, input logic [WIDTH_W-1:0] w);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    pulse_valid    <= pv;
    pulse_width_us <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has been taken.
  // Each tick yields exactly one result, so an empty expectation store
  // means the unit is idle and registers may be written.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input logic [2:0] idx, input int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input ramp_setting_t s);
    apb_write(REG_MIN_RUN,  s.min_run);
    apb_write(REG_KICK_PCT, s.kick_pct);
    apb_write(REG_KICK_MS,  s.kick_ms);
    apb_write(REG_CRAWL_MS, s.crawl_ms);
    apb_write(REG_FAIL_MS,  s.fail_ms);
    apb_write(REG_STEP_MS,  s.step_ms);
    apb_write(REG_PUNCH,    s.punch);
  endtask

  // Random ticks built from segments. Most segments model a real receiver:
  // a steady stick position with a little jitter, a pulse every few ticks.
  // The rest are signal dropouts, pure noise and bursts of bad widths.
  task automatic run_phase(input int n_ticks, input bit mid_pause);
    int left;
    int seg_len;
    int kind;
    int period;
    int base_w;
    int w;
    left = n_ticks;
    while (left > 0) begin
      kind    = $urandom_range(0, 9);
      seg_len = (kind == 7) ? $urandom_range(10, 70) : $urandom_range(5, 40);
      if (seg_len > left) seg_len = left;
      period = $urandom_range(1, 20);
      case ($urandom_range(0, 4))
        0: base_w = $urandom_range(1000, 2000);
        1: base_w = 1000;
        2: base_w = 2000;
        3: base_w = $urandom_range(800, 999);
        default: base_w = $urandom_range(2001, 2200);
      endcase
      for (int k = 0; k < seg_len; k++) begin
        if (kind <= 6) begin
          w = base_w + int'($urandom_range(0, 6)) - 3;
          send_tick(k % period == 0, WIDTH_W'(w));
        end else if (kind == 7) begin
          send_tick(1'b0, WIDTH_W'($urandom));
        end else if (kind == 8) begin
          send_tick(1'($urandom), WIDTH_W'($urandom));
        end else if ($urandom_range(0, 1) == 1) begin
          send_tick(1'b1, WIDTH_W'($urandom_range(0, 799)));
        end else begin
          send_tick(1'b1, WIDTH_W'($urandom_range(2201, 4095)));
        end
        left--;
        // Once in the run the sender holds off until the unit has caught up.
        if (mid_pause && left == n_ticks / 2) wait_drained();
      end
    end
  endtask

  initial begin : stimulus
    ramp_setting_t quick;
    ramp_setting_t plan [1:8];

    // Short kick and every-tick steps so the directed ticks reach each state.
    quick   = '{18, 100, 0, 2, 3, 0, 95};
    plan[1] = '{18, 100, 5, 10, 30, 1, 95};
    // Low extremes: no floor, smallest kick, zero failsafe, punch always on.
    plan[2] = '{0, 1, 0, 0, 0, 0, 0};
    plan[3] = '{100, 100, 3, 20, 40, 2, 101};
    // Values past 100 percent drive the compare value to full scale.
    plan[4] = '{127, 127, 1, 5, 15, 0, 127};
    plan[5] = '{25, 60, 10, 65535, 65535, 3, 80};
    // A zero kick level and the longest step period.
    plan[6] = '{10, 0, 2, 8, 25, 65535, 90};
    plan[7] = '{$urandom_range(0, 40), $urandom_range(1, 100), $urandom_range(0, 20),
                $urandom_range(0, 40), $urandom_range(0, 60), $urandom_range(0, 6),
                $urandom_range(50, 101)};
    // The longest kick never ends within the run, so it goes last.
    plan[8] = '{18, 100, 65535, 400, 200, 10, 95};

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first tick runs on the reset values: the power-up width already
    // gives a mid target, but the kick cannot start on tick zero.
    send_tick(1'b1, 12'd1500);
    wait_drained();
    apply_setting(quick);

    send_tick(1'b0, 12'd0);      // start from zero duty: kick
    send_tick(1'b1, 12'd1250);   // kick over, settle on the target
    send_tick(1'b1, 12'd1999);   // above the punch level: full duty
    send_tick(1'b1, 12'd1001);   // target rounds to zero: cut, the crawl time having run out
    send_tick(1'b1, 12'd1000);   // zero target, stays stopped
    send_tick(1'b1, 12'd2000);   // full target restarts with a kick
    send_tick(1'b1, 12'd1600);
    send_tick(1'b1, 12'd1580);   // ramp down by one step
    send_tick(1'b1, 12'd1700);   // ramp up by one step
    send_tick(1'b1, 12'd799);    // widths outside the window are ignored
    send_tick(1'b1, 12'd2201);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'd800);    // lowest accepted width: zero target, drive back on at zero duty
    send_tick(1'b1, 12'd2200);   // highest accepted width
    send_tick(1'b1, 12'd900);
    send_tick(1'b0, 12'd4095);   // pulses stop: the failsafe trips on the 4th
    send_tick(1'b0, 12'd0);
    send_tick(1'b0, 12'd2730);
    send_tick(1'b0, 12'd1365);
    send_tick(1'b1, 12'd1500);   // a fresh pulse brings the drive back

    for (int p = 1; p <= 8; p++) begin
      wait_drained();
      apply_setting(plan[p]);
      run_phase(128, p == 3);
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
